// File: rtl/eegpp_pkg.sv
// Shared types and constants for the EEG headset packet parser.
package eegpp_pkg;

    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_ATT  = 2'd1;
    localparam logic [1:0] KIND_LOST = 2'd2;

    localparam logic [1:0] REG_ADDRESS = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MAXLEN  = 2'd2;

    localparam int CFG_WIDTH = 20;

    localparam logic [15:0] ADDRESS_RESET = 16'hE027;
    localparam logic [19:0] TIMEOUT_RESET = 20'd10000;
    localparam logic [7:0]  MAXLEN_RESET  = 8'd169;
    localparam logic [19:0] ELAPSED_MAX   = 20'hFFFFF;

    localparam logic [7:0] SYNC_BYTE      = 8'd170;
    localparam logic [7:0] CMD_DISCONNECT = 8'hC1;
    localparam logic [7:0] CMD_CONNECT_TO = 8'hC0;

    localparam logic [7:0] CODE_BIG       = 8'h02;
    localparam logic [7:0] CODE_ATTENTION = 8'h04;
    localparam logic [7:0] CODE_SKIP1     = 8'h05;
    localparam logic [7:0] CODE_SKIP3     = 8'h80;
    localparam logic [7:0] CODE_SKIP25    = 8'h83;
    localparam logic [7:0] CODE_RECON_LO  = 8'hD1;
    localparam logic [7:0] CODE_RECON_HI  = 8'hD4;

    typedef enum logic [2:0] {
        RS_LOST,
        RS_C1,
        RS_C0,
        RS_AHI,
        RS_ALO,
        RS_ATT
    } res_sel_t;

    typedef struct packed {
        logic     len_load;
        logic     pay_take;
        logic     walk_start;
        logic     walk_step;
        logic     att_take;
        logic     tick;
        logic     timer_start;
        logic     out_load;
        res_sel_t out_sel;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic is_sync;
        logic len_bad;
        logic len_zero;
        logic pay_done;
        logic sum_ok;
        logic walk_more;
        logic code_att;
        logic att_in_range;
        logic expire;
        logic big;
        logic recon;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/eegpp_datapath.sv
// Datapath: configuration, packet counters, payload memory, walk registers, timer, result register.
module eegpp_datapath import eegpp_pkg::*; #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    input  logic [7:0]           in_byte,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [7:0]           m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);
    localparam logic [8:0] DEPTH_LIMIT = 9'(PAYLOAD_DEPTH);

    logic [15:0] address_reg;
    logic [19:0] timeout_reg;
    logic [7:0]  maxlen_reg;

    logic [7:0]  len_reg;
    logic [7:0]  taken_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  mem [PAYLOAD_DEPTH];
    logic [7:0]  rdata_reg;

    logic [8:0]  idx_reg;
    logic [8:0]  idx_next;
    logic [7:0]  att_reg;
    logic        big_reg;
    logic        recon_reg;

    logic [19:0] elapsed_reg;
    logic        running_reg;
    logic [19:0] elapsed_sat;

    logic        tvalid_reg;
    logic [7:0]  tdata_reg;
    logic [1:0]  tuser_reg;
    logic        tlast_reg;
    logic [7:0]  out_value;
    logic [1:0]  out_kind;

    assign elapsed_sat = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 20'd1;

    always_comb begin
        sts.is_sync      = (in_byte == SYNC_BYTE);
        sts.len_bad      = (in_byte > maxlen_reg) || ({1'b0, in_byte} > DEPTH_LIMIT);
        sts.len_zero     = (in_byte == 8'd0);
        sts.pay_done     = ({1'b0, taken_reg} + 9'd1) >= {1'b0, len_reg};
        sts.sum_ok       = (in_byte == ~sum_reg);
        sts.walk_more    = (idx_reg < {1'b0, len_reg});
        sts.code_att     = (rdata_reg == CODE_ATTENTION);
        sts.att_in_range = (idx_reg + 9'd1) < {1'b0, len_reg};
        sts.expire       = running_reg && (elapsed_sat > timeout_reg);
        sts.big          = big_reg;
        sts.recon        = recon_reg;
        sts.out_free     = !tvalid_reg || m_tready;
    end

    always_comb begin
        priority if (rdata_reg == CODE_BIG || rdata_reg == CODE_SKIP1) begin
            idx_next = idx_reg + 9'd2;
        end else if (rdata_reg == CODE_ATTENTION) begin
            idx_next = sts.att_in_range ? idx_reg + 9'd1 : idx_reg + 9'd2;
        end else if (rdata_reg == CODE_SKIP3) begin
            idx_next = idx_reg + 9'd4;
        end else if (rdata_reg == CODE_SKIP25) begin
            idx_next = idx_reg + 9'd26;
        end else begin
            idx_next = idx_reg + 9'd1;
        end
    end

    always_comb begin
        out_kind = KIND_SEND;
        unique case (cmd.out_sel)
            RS_LOST: begin
                out_kind  = KIND_LOST;
                out_value = 8'd0;
            end
            RS_C1:  out_value = CMD_DISCONNECT;
            RS_C0:  out_value = CMD_CONNECT_TO;
            RS_AHI: out_value = address_reg[15:8];
            RS_ALO: out_value = address_reg[7:0];
            RS_ATT: begin
                out_kind  = KIND_ATT;
                out_value = att_reg;
            end
            default: out_value = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.pay_take) begin
            mem[taken_reg[AW-1:0]] <= in_byte;
        end
        rdata_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_reg <= ADDRESS_RESET;
            timeout_reg <= TIMEOUT_RESET;
            maxlen_reg  <= MAXLEN_RESET;
            len_reg     <= 8'd0;
            taken_reg   <= 8'd0;
            sum_reg     <= 8'd0;
            idx_reg     <= 9'd0;
            att_reg     <= 8'd0;
            big_reg     <= 1'b0;
            recon_reg   <= 1'b0;
            elapsed_reg <= 20'd0;
            running_reg <= 1'b0;
            tvalid_reg  <= 1'b0;
            tdata_reg   <= 8'd0;
            tuser_reg   <= KIND_SEND;
            tlast_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_ADDRESS: address_reg <= cfg_wdata[15:0];
                    REG_TIMEOUT: timeout_reg <= cfg_wdata;
                    REG_MAXLEN:  maxlen_reg  <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (cmd.len_load) begin
                len_reg   <= in_byte;
                taken_reg <= 8'd0;
                sum_reg   <= 8'd0;
            end
            if (cmd.pay_take) begin
                sum_reg   <= sum_reg + in_byte;
                taken_reg <= taken_reg + 8'd1;
            end
            if (cmd.walk_start) begin
                idx_reg   <= 9'd0;
                att_reg   <= 8'd0;
                big_reg   <= 1'b0;
                recon_reg <= 1'b0;
            end
            if (cmd.walk_step) begin
                idx_reg <= idx_next;
                if (rdata_reg == CODE_BIG) begin
                    big_reg <= 1'b1;
                end
                if (rdata_reg == CODE_ATTENTION && !sts.att_in_range) begin
                    att_reg <= 8'd0;
                end
                if (rdata_reg >= CODE_RECON_LO && rdata_reg <= CODE_RECON_HI) begin
                    recon_reg <= 1'b1;
                end
            end
            if (cmd.att_take) begin
                att_reg <= rdata_reg;
                idx_reg <= idx_reg + 9'd1;
            end
            if (cmd.tick && running_reg) begin
                if (sts.expire) begin
                    elapsed_reg <= 20'd0;
                    running_reg <= 1'b0;
                end else begin
                    elapsed_reg <= elapsed_sat;
                end
            end
            if (cmd.timer_start) begin
                elapsed_reg <= 20'd0;
                running_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                tvalid_reg <= 1'b1;
                tdata_reg  <= out_value;
                tuser_reg  <= out_kind;
                tlast_reg  <= cmd.out_last;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

// File: rtl/eegpp_ctrl.sv
// Controller: packet phase tracking, payload walk sequencing and result emission.
module eegpp_ctrl import eegpp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] action,
    output logic       s_tready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CODE,
        ST_AFETCH,
        ST_ATT_TAKE,
        ST_LOST,
        ST_C1,
        ST_C0,
        ST_AHI,
        ST_ALO,
        ST_ATT
    } state_t;

    phase_t phase_reg, phase_next;
    state_t state_reg, state_next;
    logic   send_att_reg, send_att_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd           = '0;
        cmd.out_sel   = RS_LOST;
        phase_next    = phase_reg;
        state_next    = state_reg;
        send_att_next = send_att_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (action)
                        ACT_BYTE: begin
                            unique case (phase_reg)
                                PH_SYNC1: begin
                                    if (sts.is_sync) begin
                                        phase_next = PH_SYNC2;
                                    end
                                end
                                PH_SYNC2: phase_next = sts.is_sync ? PH_LENGTH : PH_SYNC1;
                                PH_LENGTH: begin
                                    if (sts.len_bad) begin
                                        phase_next = PH_SYNC1;
                                    end else begin
                                        cmd.len_load = 1'b1;
                                        phase_next   = sts.len_zero ? PH_CHECK : PH_PAYLOAD;
                                    end
                                end
                                PH_PAYLOAD: begin
                                    cmd.pay_take = 1'b1;
                                    if (sts.pay_done) begin
                                        phase_next = PH_CHECK;
                                    end
                                end
                                PH_CHECK: begin
                                    phase_next = PH_SYNC1;
                                    if (sts.sum_ok) begin
                                        cmd.walk_start = 1'b1;
                                        state_next     = ST_FETCH;
                                    end
                                end
                                default: phase_next = PH_SYNC1;
                            endcase
                        end
                        ACT_TIMEOUT: phase_next = PH_SYNC1;
                        ACT_TICK: begin
                            cmd.tick = 1'b1;
                            if (sts.expire) begin
                                send_att_next = 1'b0;
                                state_next    = ST_LOST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                if (!sts.walk_more) begin
                    cmd.timer_start = sts.big;
                    send_att_next   = sts.big;
                    priority if (sts.recon) begin
                        state_next = ST_C1;
                    end else if (sts.big) begin
                        state_next = ST_ATT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_CODE;
                end
            end
            ST_CODE: begin
                cmd.walk_step = 1'b1;
                state_next = (sts.code_att && sts.att_in_range) ? ST_AFETCH : ST_FETCH;
            end
            ST_AFETCH: state_next = ST_ATT_TAKE;
            ST_ATT_TAKE: begin
                cmd.att_take = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_LOST: begin
                cmd.out_sel = RS_LOST;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_C1;
                end
            end
            ST_C1: begin
                cmd.out_sel = RS_C1;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_C0;
                end
            end
            ST_C0: begin
                cmd.out_sel = RS_C0;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_AHI;
                end
            end
            ST_AHI: begin
                cmd.out_sel = RS_AHI;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ALO;
                end
            end
            ST_ALO: begin
                cmd.out_sel  = RS_ALO;
                cmd.out_last = !send_att_reg;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = send_att_reg ? ST_ATT : ST_IDLE;
                end
            end
            ST_ATT: begin
                cmd.out_sel  = RS_ATT;
                cmd.out_last = 1'b1;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC1;
            state_reg    <= ST_IDLE;
            send_att_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            state_reg    <= state_next;
            send_att_reg <= send_att_next;
        end
    end

endmodule

// File: rtl/eeg_headset_packet_parser_top.sv
// Top level of the EEG headset packet parser with link watchdog.
// Each transfer (received byte, read timeout or millisecond tick) is taken only while the
// parser is idle. After a packet's checksum byte matches, the parser walks the buffered
// payload through the single read port of the payload memory: each code is fetched, then decoded;
// an attention code with its value in range also fetches and takes it; a last fetch ends the walk.
// Results leave through a one-entry output register at one per cycle while the sink is ready;
// an item that produces results holds off the next transfer until its last result is loaded.
module eeg_headset_packet_parser_top import eegpp_pkg::*; #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic [1:0]           s_tuser,   // [1:0] action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] value
    output logic [1:0]           m_tuser,   // [1:0] kind
    output logic                 m_tlast
);

    cmd_t cmd;
    sts_t sts;

    eegpp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    eegpp_datapath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: rtl/eegpp_checker.sv
// Port-level assertions for the packet parser, bound to the top level.
module eegpp_checker import eegpp_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_timeout_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_TIMEOUT |=> !$rose(m_tvalid))
        else $error("read timeout produced a result");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == KIND_SEND || m_tuser == KIND_ATT || m_tuser == KIND_LOST)
        else $error("illegal result kind");

    a_lost_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_LOST |-> m_tdata == 8'd0 && !m_tlast)
        else $error("link lost result malformed");

    a_att_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ATT |-> m_tlast)
        else $error("attention result not last");

endmodule

bind eeg_headset_packet_parser_top eegpp_checker u_eegpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/tb.sv
// Testbench for the EEG headset packet parser: random and directed streams against a model.
module tb;
    import eegpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH         = 256;
    localparam int         SETTLE_CYCLES = 600;
    localparam int         HOLD_CYCLES   = 300;
    localparam logic [1:0] ACT_UNUSED    = 2'd3;

    typedef enum logic [2:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        TAKE_LENGTH,
        TAKE_PAYLOAD,
        TAKE_CHECKSUM
    } parse_phase_t;

    typedef struct {
        logic [1:0] action;
        logic [7:0] data;
        int         gap;
    } rx_event_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } parser_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_addr  = REG_ADDRESS;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'd0;   // [7:0] rx_byte
    logic [1:0]           s_tuser   = ACT_BYTE; // [1:0] action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;            // [7:0] value
    logic [1:0]           m_tuser;            // [1:0] kind
    logic                 m_tlast;

    eeg_headset_packet_parser_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // parser model state
    logic [15:0]  mdl_address  = ADDRESS_RESET;
    logic [19:0]  mdl_timeout  = TIMEOUT_RESET;
    logic [7:0]   mdl_max_len  = MAXLEN_RESET;
    parse_phase_t parse_phase  = HUNT_SYNC1;
    int           pkt_len      = 0;
    int           bytes_in     = 0;
    logic [7:0]   pay_sum      = 8'd0;
    logic [7:0]   payload_mem [DEPTH];
    logic [19:0]  elapsed      = 20'd0;
    logic         timer_on     = 1'b0;

    parser_result_t result_burst[$];
    parser_result_t expected_results[$];
    rx_event_t      pending_items[$];
    logic [7:0]     body_buf[$];

    int  fail_count        = 0;
    int  transfers_planned = 0;
    int  transfers_in      = 0;
    int  results_seen      = 0;
    int  good_packets      = 0;
    int  link_losses       = 0;
    int  settings_used     = 0;
    int  sink_wait         = 0;
    int  sink_hold_left    = 0;
    bit  sink_hold_req     = 1'b0;
    bit  sink_calm         = 1'b0;
    bit  send_calm         = 1'b0;
    bit  transfer_done     = 1'b0;
    bit  next_valid        = 1'b0;
    rx_event_t cur_item;

    function automatic void queue_reconnect();
        result_burst.push_back('{KIND_SEND, CMD_DISCONNECT, 1'b0});
        result_burst.push_back('{KIND_SEND, CMD_CONNECT_TO, 1'b0});
        result_burst.push_back('{KIND_SEND, mdl_address[15:8], 1'b0});
        result_burst.push_back('{KIND_SEND, mdl_address[7:0], 1'b0});
    endfunction

    function automatic logic [7:0] stored_byte(int idx);
        if (idx < pkt_len && idx < DEPTH) begin
            return payload_mem[idx];
        end
        return 8'd0;
    endfunction

    function automatic void walk_payload();
        int         pos       = 0;
        logic [7:0] code;
        logic [7:0] attention = 8'd0;
        bit         big       = 1'b0;
        bit         recon     = 1'b0;
        while (pos < pkt_len) begin
            code = stored_byte(pos);
            if (code == CODE_BIG) begin
                pos++;
                big = 1'b1;
            end else if (code == CODE_ATTENTION) begin
                pos++;
                attention = stored_byte(pos);
            end else if (code == CODE_SKIP1) begin
                pos++;
            end else if (code >= CODE_RECON_LO && code <= CODE_RECON_HI) begin
                recon = 1'b1;
            end else if (code == CODE_SKIP3) begin
                pos += 3;
            end else if (code == CODE_SKIP25) begin
                pos += 25;
            end
            pos++;
        end
        if (recon) begin
            queue_reconnect();
        end
        if (big) begin
            result_burst.push_back('{KIND_ATT, attention, 1'b0});
            elapsed  = 20'd0;
            timer_on = 1'b1;
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        case (parse_phase)
            HUNT_SYNC1: begin
                if (b == SYNC_BYTE) parse_phase = HUNT_SYNC2;
            end
            HUNT_SYNC2: begin
                parse_phase = (b == SYNC_BYTE) ? TAKE_LENGTH : HUNT_SYNC1;
            end
            TAKE_LENGTH: begin
                if (b > mdl_max_len || int'(b) > DEPTH) begin
                    parse_phase = HUNT_SYNC1;
                end else begin
                    pkt_len     = int'(b);
                    bytes_in    = 0;
                    pay_sum     = 8'd0;
                    parse_phase = (b == 8'd0) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD: begin
                if (bytes_in < DEPTH) payload_mem[bytes_in] = b;
                pay_sum  = pay_sum + b;
                bytes_in = (bytes_in + 1) & 255;
                if (bytes_in >= pkt_len) parse_phase = TAKE_CHECKSUM;
            end
            TAKE_CHECKSUM: begin
                parse_phase = HUNT_SYNC1;
                if (b == 8'hFF - pay_sum) begin
                    good_packets++;
                    walk_payload();
                end
            end
            default: begin
                parse_phase = HUNT_SYNC1;
            end
        endcase
    endfunction

    function automatic void count_tick();
        if (timer_on) begin
            if (elapsed < ELAPSED_MAX) elapsed = elapsed + 20'd1;
            if (elapsed > mdl_timeout) begin
                result_burst.push_back('{KIND_LOST, 8'd0, 1'b0});
                elapsed  = 20'd0;
                timer_on = 1'b0;
                link_losses++;
                queue_reconnect();
            end
        end
    endfunction

    function automatic void predict_parser_results(logic [1:0] action, logic [7:0] data);
        result_burst.delete();
        if (action == ACT_BYTE) begin
            parse_byte(data);
        end else if (action == ACT_TIMEOUT) begin
            parse_phase = HUNT_SYNC1;
        end else if (action == ACT_TICK) begin
            count_tick();
        end
        if (result_burst.size() > 0) begin
            result_burst[result_burst.size() - 1].last = 1'b1;
        end
        foreach (result_burst[k]) expected_results.push_back(result_burst[k]);
    endfunction

    // accept transfers, check results, track register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ADDRESS: mdl_address = cfg_wdata[15:0];
                    REG_TIMEOUT: mdl_timeout = cfg_wdata[19:0];
                    REG_MAXLEN:  mdl_max_len = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d value %0d last %0d",
                           m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    parser_result_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (m_tuser !== exp_res.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", exp_res.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== exp_res.value) begin
                        $error("value mismatch: expected 0x%02h, actual 0x%02h",
                               exp_res.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== exp_res.last) begin
                        $error("last mismatch: expected %0d, actual %0d", exp_res.last, m_tlast);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 7);
            end
            if (s_tvalid && s_tready) begin
                predict_parser_results(s_tuser, s_tdata);
                transfers_in++;
                transfer_done = 1'b1;
            end
        end
    end

    // sender
    always @(negedge aclk) begin
        next_valid = s_tvalid;
        if (transfer_done) begin
            transfer_done = 1'b0;
            next_valid    = 1'b0;
        end
        if (!next_valid && aresetn && pending_items.size() != 0) begin
            if (pending_items[0].gap != 0) begin
                pending_items[0].gap = pending_items[0].gap - 1;
            end else begin
                cur_item = pending_items.pop_front();
                s_tdata    <= cur_item.data;
                s_tuser    <= cur_item.action;
                next_valid = 1'b1;
            end
        end
        s_tvalid <= next_valid;
    end

    // receiver
    always @(negedge aclk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_tready <= 1'b0;
        end else if (sink_hold_req) begin
            sink_hold_req  = 1'b0;
            sink_hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void push_event(logic [1:0] action, logic [7:0] data);
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        pending_items.push_back('{action, data, send_calm ? 0 : int'($urandom_range(0, 7))});
        transfers_planned++;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        push_event(ACT_BYTE, b);
    endfunction

    function automatic void fill_body(int len);
        int pick;
        body_buf.delete();
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 16) body_buf.push_back(CODE_BIG);
            else if (pick < 32) body_buf.push_back(CODE_ATTENTION);
            else if (pick < 38) body_buf.push_back(CODE_SKIP1);
            else if (pick < 44) body_buf.push_back(CODE_SKIP3);
            else if (pick < 47) body_buf.push_back(CODE_SKIP25);
            else if (pick < 55) body_buf.push_back(8'(CODE_RECON_LO + $urandom_range(0, 3)));
            else body_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void push_packet(bit corrupt);
        logic [7:0] sum = 8'd0;
        logic [7:0] chk;
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(8'(body_buf.size()));
        foreach (body_buf[k]) begin
            push_byte(body_buf[k]);
            sum = sum + body_buf[k];
        end
        chk = 8'hFF - sum;
        if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
        push_byte(chk);
    endfunction

    function automatic void random_phase(int count, int len_cap);
        int stop_at;
        int pick;
        int len;
        int cut;
        stop_at = transfers_planned + count;
        while (transfers_planned < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 19) == 0) len = $urandom_range(0, len_cap);
                else len = $urandom_range(0, (len_cap < 12) ? len_cap : 12);
                fill_body(len);
                push_packet($urandom_range(0, 9) == 0);
            end else if (pick < 62) begin
                len = $urandom_range(1, 8);
                cut = $urandom_range(0, len);
                fill_body(len);
                push_byte(SYNC_BYTE);
                push_byte(SYNC_BYTE);
                push_byte(8'(len));
                for (int k = 0; k < cut; k++) push_byte(body_buf[k]);
                push_event(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
            end else if (pick < 67) begin
                push_byte(SYNC_BYTE);
                push_byte(8'($urandom_range(0, 255)));
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 4)) push_event(ACT_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                push_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                push_event(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
            end else begin
                push_event(ACT_UNUSED, 8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic apply_setting(logic [15:0] address, logic [19:0] timeout, logic [7:0] max_len);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_ADDRESS;
        cfg_wdata <= CFG_WIDTH'(address);
        @(negedge aclk);
        cfg_addr  <= REG_TIMEOUT;
        cfg_wdata <= CFG_WIDTH'(timeout);
        @(negedge aclk);
        cfg_addr  <= REG_MAXLEN;
        cfg_wdata <= CFG_WIDTH'(max_len);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic await_drain();
        while (transfers_in != transfers_planned || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [7:0] max_len;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apply_setting(16'hA55A, 20'd1, MAXLEN_RESET);
        push_event(ACT_TICK, 8'hFF);
        push_event(ACT_UNUSED, 8'h00);
        push_byte(SYNC_BYTE);
        push_byte(8'h55);
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(MAXLEN_RESET + 8'd1);
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(8'd2);
        push_event(ACT_TIMEOUT, 8'h00);
        body_buf.delete();
        push_packet(1'b1);
        push_packet(1'b0);
        body_buf = '{CODE_RECON_LO, CODE_RECON_HI, CODE_BIG, 8'hFF, CODE_ATTENTION, 8'h37,
                     CODE_SKIP1, CODE_ATTENTION, CODE_SKIP3, 8'h01, 8'h02, 8'h03,
                     CODE_ATTENTION};
        push_packet(1'b0);
        push_event(ACT_TICK, 8'h00);
        push_event(ACT_TICK, 8'hFF);
        body_buf = '{CODE_ATTENTION, 8'hFF, CODE_BIG, 8'h00, CODE_SKIP25, CODE_ATTENTION,
                     8'h01};
        push_packet(1'b0);
        await_drain();

        apply_setting(16'h0000, 20'd3, 8'd255);
        fill_body(100);
        body_buf[0] = CODE_BIG;
        push_packet(1'b0);
        random_phase(30, 20);
        await_drain();

        apply_setting(16'hFFFF, 20'd1000000, 8'd0);
        random_phase(15, 3);
        await_drain();

        max_len = 8'($urandom_range(8, 40));
        apply_setting(16'($urandom_range(0, 65535)), 20'($urandom_range(1, 8)), max_len);
        sink_hold_req = 1'b1;
        random_phase(35, int'(max_len) + 4);
        await_drain();

        apply_setting(16'($urandom_range(0, 65535)), 20'd2, 8'd255);
        random_phase(15, 20);
        await_drain();

        $display("Run covered %0d transfers over %0d register settings.",
                 transfers_in, settings_used);
        $display("%0d results checked, %0d packets passed checksum, %0d link losses.",
                 results_seen, good_packets, link_losses);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
